FILE: rtl/adlg_pkg.sv
// ----------------------------------------------------------------------------
// adlg_pkg - shared types and constants of the adjacent duplicate line grouper
// Item codes, byte constants, register indexes, queue sizes, the transaction
// types that pass between the parts and the helper that builds a result.
// ----------------------------------------------------------------------------
package adlg_pkg;

   // request type codes
   localparam logic REQ_TEXT = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // bytes of interest
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELDS_TO_SKIP  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_SKIP       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_SKIP_EXTRA = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_UNIQUE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_DUPLICATE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_COUNT    = 3'd5;

   // queue between front and back, and result queue
   localparam int MQ_DEPTH = 4;
   localparam int OQ_DEPTH = 4;
   localparam int OQ_PW    = $clog2(OQ_DEPTH);
   localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

   // one classified byte or end-of-input marker
   typedef struct packed {
      logic       eoi;
      logic [7:0] text_byte;
      logic       is_key;
      logic       in_range;
   } key_item_type;

   // one closed group
   typedef struct packed {
      logic [31:0] group_first_line;
      logic [15:0] group_size;
      logic        emit_line;
      logic        with_count;
      logic        key_overflow;
      logic        last;
   } result_type;

   function automatic result_type make_result(
      input logic [31:0] first_line,
      input logic [15:0] size,
      input logic        ovf,
      input logic        show_unique,
      input logic        show_duplicate,
      input logic        prefix_count,
      input logic        is_last
   );
      result_type r;
      logic       many;
      many               = (size != 16'd1);
      r.group_first_line = first_line;
      r.group_size       = size;
      r.emit_line        = prefix_count | (show_unique & ~many) | (show_duplicate & many);
      r.with_count       = prefix_count;
      r.key_overflow     = ovf;
      r.last             = is_last;
      return r;
   endfunction

endpackage

FILE: rtl/adlg_ram.sv
// ----------------------------------------------------------------------------
// adlg_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered under a read enable.
// ----------------------------------------------------------------------------
module adlg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/adlg_fifo.sv
// ----------------------------------------------------------------------------
// adlg_fifo - small register queue
// Decouples the classifying front from the comparing back.
// ----------------------------------------------------------------------------
module adlg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      full      = (count_ff == CW'(DEPTH));
      pop_valid = (count_ff != '0);
      pop_data  = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/adlg_front.sv
// ----------------------------------------------------------------------------
// adlg_front - byte classifier
// Accepts request transactions, tracks the field and character skip of the
// current line and marks key bytes with their position in the key.
// ----------------------------------------------------------------------------
module adlg_front #(
   parameter int KEY_MAX = 256,
   localparam int AW = $clog2(KEY_MAX)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [7:0]            req_text_byte,
   input  logic [7:0]            fields_to_skip,
   input  logic [15:0]           char_skip,
   input  logic [15:0]           char_skip_extra,
   input  logic                  q_full,
   output logic                  q_push,
   output adlg_pkg::key_item_type q_item,
   output logic [AW-1:0]         q_addr
);

   import adlg_pkg::*;

   localparam int KW = $clog2(KEY_MAX + 1);
   localparam logic [KW-1:0] KP_MAX = KW'(KEY_MAX);

   localparam logic [1:0] PH_BLANKS = 2'd0;
   localparam logic [1:0] PH_FIELD  = 2'd1;
   localparam logic [1:0] PH_CHARS  = 2'd2;
   localparam logic [1:0] PH_KEY    = 2'd3;

   logic          line_open_ff, line_open_in;
   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    fd_ff, fd_in;
   logic [16:0]   cd_ff, cd_in;
   logic [KW-1:0] kp_ff, kp_in;

   logic [1:0]    phase0;
   logic [7:0]    fd0, fd_inc;
   logic [16:0]   cd0, total;
   logic [KW-1:0] kp0;
   logic          blank, is_key, to_chars, accept;

   always_comb begin
      accept    = req_valid && !q_full;
      req_stall = q_full;

      // a new line takes its starting phase from the registers now
      phase0 = line_open_ff ? phase_ff :
               ((fields_to_skip != 8'd0) ? PH_BLANKS : PH_CHARS);
      fd0    = line_open_ff ? fd_ff : '0;
      cd0    = line_open_ff ? cd_ff : '0;
      kp0    = line_open_ff ? kp_ff : '0;
      total  = {1'b0, char_skip} + {1'b0, char_skip_extra};
      blank  = (req_text_byte == CH_SPACE) || (req_text_byte == CH_TAB);
      fd_inc = (fd0 != 8'hFF) ? fd0 + 8'd1 : fd0;

      phase_in = phase0;
      fd_in    = fd0;
      cd_in    = cd0;
      is_key   = 1'b0;
      to_chars = 1'b0;

      unique case (phase0)
         PH_BLANKS: begin
            if (!blank) phase_in = PH_FIELD;
         end
         PH_FIELD: begin
            if (blank) begin
               fd_in = fd_inc;
               if (fd_inc < fields_to_skip) begin
                  phase_in = PH_BLANKS;
               end else begin
                  to_chars = 1'b1;
               end
            end
         end
         PH_CHARS: to_chars = 1'b1;
         PH_KEY:   is_key = 1'b1;
         default:  is_key = 1'b0;
      endcase

      // the blank that ends the last field falls straight into the char skip
      if (to_chars) begin
         if (cd0 < total) begin
            cd_in    = cd0 + 17'd1;
            phase_in = PH_CHARS;
         end else begin
            phase_in = PH_KEY;
            is_key   = 1'b1;
         end
      end

      kp_in        = (is_key && kp0 != KP_MAX) ? kp0 + KW'(1) : kp0;
      line_open_in = (req_text_byte != CH_NEWLINE);

      if (req_type == REQ_END) begin
         line_open_in = 1'b0;
         phase_in     = PH_BLANKS;
         fd_in        = '0;
         cd_in        = '0;
         kp_in        = '0;
      end

      q_push           = accept;
      q_item.eoi       = (req_type == REQ_END);
      q_item.text_byte = req_text_byte;
      q_item.is_key    = is_key && (req_type == REQ_TEXT);
      q_item.in_range  = (kp0 != KP_MAX);
      q_addr           = kp0[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_open_ff <= 1'b0;
         phase_ff     <= PH_BLANKS;
         fd_ff        <= '0;
         cd_ff        <= '0;
         kp_ff        <= '0;
      end else if (accept) begin
         line_open_ff <= line_open_in;
         phase_ff     <= phase_in;
         fd_ff        <= fd_in;
         cd_ff        <= cd_in;
         kp_ff        <= kp_in;
      end
   end

endmodule

FILE: rtl/adlg_back.sv
// ----------------------------------------------------------------------------
// adlg_back - key compare and group tracker
// Reads the group's key byte and writes the current one in the two-bank line
// store, compares in the compare stage, closes lines and groups, queues results.
// ----------------------------------------------------------------------------
module adlg_back #(
   parameter int KEY_MAX = 256,
   localparam int AW = $clog2(KEY_MAX)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  adlg_pkg::key_item_type q_item,
   input  logic [AW-1:0]          q_addr,
   output logic                   q_pop,
   input  logic                   show_unique,
   input  logic                   show_duplicate,
   input  logic                   prefix_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output adlg_pkg::result_type   rsp_data
);

   import adlg_pkg::*;

   // compare stage
   logic         b_valid_ff, b_valid_in;
   key_item_type b_item_ff;

   // group state
   logic        sel_ff, sel_in;
   logic [31:0] prev_len_ff, prev_len_in;
   logic [31:0] cur_len_ff, cur_len_in;
   logic        mm_ff, mm_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [31:0] line_ff, line_in;
   logic [31:0] start_ff, start_in;
   logic        have_ff, have_in;
   logic        open_ff, open_in;
   logic        ovfs_ff, ovfs_in;

   // result queue
   result_type     oq_mem_ff [OQ_DEPTH];
   logic [OQ_PW-1:0] oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic [OQ_CW-1:0] oq_count_ff, oq_count_in;

   logic        a_fire, b_go, we0, we1, pop;
   logic [7:0]  rd0, rd1, rd_byte;
   logic        text, key_b, mm_k, mm1, close, equal, ovf, close_emit, eoi_emit;
   logic [31:0] len1;
   logic [15:0] cnt2;
   logic [31:0] start2;
   logic        ovfs2, have2, sel2;
   logic [31:0] prev_len2;
   logic [1:0]  push_n;
   result_type  res_old, res_new, res_first;

   // ---- store access, using the bank select the compare stage settles now
   always_comb begin
      b_go   = b_valid_ff && (oq_count_ff <= OQ_CW'(OQ_DEPTH - 2));
      a_fire = q_valid && (!b_valid_ff || b_go);
      q_pop  = a_fire;
      we0    = a_fire && q_item.is_key && q_item.in_range && sel_in;
      we1    = a_fire && q_item.is_key && q_item.in_range && !sel_in;
      b_valid_in = a_fire ? 1'b1 : (b_go ? 1'b0 : b_valid_ff);
   end

   adlg_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_bank0 (
      .clock   (clock),
      .wr_en   (we0),
      .wr_addr (q_addr),
      .wr_data (q_item.text_byte),
      .rd_en   (a_fire),
      .rd_addr (q_addr),
      .rd_data (rd0)
   );

   adlg_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_bank1 (
      .clock   (clock),
      .wr_en   (we1),
      .wr_addr (q_addr),
      .wr_data (q_item.text_byte),
      .rd_en   (a_fire),
      .rd_addr (q_addr),
      .rd_data (rd1)
   );

   // ---- compare and close
   always_comb begin
      text    = !b_item_ff.eoi;
      key_b   = text && b_item_ff.is_key;
      rd_byte = sel_ff ? rd1 : rd0;

      mm_k = mm_ff || (cur_len_ff >= prev_len_ff) ||
             (b_item_ff.in_range && have_ff && (rd_byte != b_item_ff.text_byte));
      mm1  = key_b ? mm_k : mm_ff;
      len1 = (key_b && cur_len_ff != 32'hFFFF_FFFF) ? cur_len_ff + 32'd1 : cur_len_ff;

      close      = text ? (b_item_ff.text_byte == CH_NEWLINE) : open_ff;
      equal      = have_ff && !mm1 && (len1 == prev_len_ff);
      ovf        = (len1 > 32'(KEY_MAX));
      close_emit = close && !equal && have_ff;

      cnt2      = cnt_ff;
      start2    = start_ff;
      ovfs2     = ovfs_ff;
      sel2      = sel_ff;
      prev_len2 = prev_len_ff;
      have2     = have_ff || close;
      if (close) begin
         if (equal) begin
            cnt2  = (cnt_ff != 16'hFFFF) ? cnt_ff + 16'd1 : cnt_ff;
            ovfs2 = ovfs_ff || ovf;
         end else begin
            cnt2      = 16'd1;
            start2    = line_ff;
            ovfs2     = ovf;
            sel2      = !sel_ff;
            prev_len2 = len1;
         end
      end
      eoi_emit = !text && have2;

      sel_in      = sel_ff;
      prev_len_in = prev_len_ff;
      cur_len_in  = cur_len_ff;
      mm_in       = mm_ff;
      cnt_in      = cnt_ff;
      line_in     = line_ff;
      start_in    = start_ff;
      have_in     = have_ff;
      open_in     = open_ff;
      ovfs_in     = ovfs_ff;
      if (b_go) begin
         if (!text) begin
            // end of input: restart the stream
            sel_in      = 1'b0;
            prev_len_in = '0;
            cur_len_in  = '0;
            mm_in       = 1'b0;
            cnt_in      = '0;
            line_in     = '0;
            start_in    = '0;
            have_in     = 1'b0;
            open_in     = 1'b0;
            ovfs_in     = 1'b0;
         end else begin
            sel_in      = sel2;
            prev_len_in = prev_len2;
            cnt_in      = cnt2;
            start_in    = start2;
            have_in     = have2;
            ovfs_in     = ovfs2;
            cur_len_in  = close ? '0 : len1;
            mm_in       = close ? 1'b0 : mm1;
            open_in     = !close;
            line_in     = close ? line_ff + 32'd1 : line_ff;
         end
      end

      res_old   = make_result(start_ff, cnt_ff, ovfs_ff, show_unique, show_duplicate,
                              prefix_count, !eoi_emit);
      res_new   = make_result(start2, cnt2, ovfs2, show_unique, show_duplicate,
                              prefix_count, 1'b1);
      res_first = close_emit ? res_old : res_new;
      push_n    = b_go ? (2'(close_emit) + 2'(eoi_emit)) : 2'd0;

      pop         = rsp_valid && !rsp_stall;
      oq_wr_in    = oq_wr_ff + OQ_PW'(push_n);
      oq_rd_in    = pop ? oq_rd_ff + OQ_PW'(1) : oq_rd_ff;
      oq_count_in = oq_count_ff + OQ_CW'(push_n) - OQ_CW'(pop);
   end

   assign rsp_valid = (oq_count_ff != '0);
   assign rsp_data  = oq_mem_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         sel_ff      <= 1'b0;
         prev_len_ff <= '0;
         cur_len_ff  <= '0;
         mm_ff       <= 1'b0;
         cnt_ff      <= '0;
         line_ff     <= '0;
         start_ff    <= '0;
         have_ff     <= 1'b0;
         open_ff     <= 1'b0;
         ovfs_ff     <= 1'b0;
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_count_ff <= '0;
      end else begin
         b_valid_ff  <= b_valid_in;
         sel_ff      <= sel_in;
         prev_len_ff <= prev_len_in;
         cur_len_ff  <= cur_len_in;
         mm_ff       <= mm_in;
         cnt_ff      <= cnt_in;
         line_ff     <= line_in;
         start_ff    <= start_in;
         have_ff     <= have_in;
         open_ff     <= open_in;
         ovfs_ff     <= ovfs_in;
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_count_ff <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         b_item_ff <= q_item;
      end
      if (push_n != 2'd0) begin
         oq_mem_ff[oq_wr_ff] <= res_first;
      end
      if (push_n == 2'd2) begin
         oq_mem_ff[oq_wr_ff + OQ_PW'(1)] <= res_new;
      end
   end

endmodule

FILE: rtl/adjacent_duplicate_line_grouper.sv
// ----------------------------------------------------------------------------
// adjacent_duplicate_line_grouper - groups equal adjacent lines of a text stream
// Top level: configuration registers, front classifier, queue, back compare.
// ----------------------------------------------------------------------------
// Feed the text one byte per request transaction (req_type low) and close the
// stream with an end-of-input transaction (req_type high). The block sustains
// one request transaction per clock cycle unless stalled: every key byte
// costs one read and one write of the two-bank line store, each bank being
// its own RAM, and both happen in the same cycle. rsp_valid rises once the
// byte closing a group clears the compare stage; an end-of-input transaction
// may give two result transactions, the second flagged with rsp_last, and
// rsp_last marks the final result of every request. Results wait in a
// four-entry queue, so a stalled result side backs up into the request queue
// before req_stall rises. The line store is not cleared after reset; only
// entries written by the current group's first line are ever compared. Write
// the configuration registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
module adjacent_duplicate_line_grouper #(
   parameter int KEY_MAX = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [7:0]                       req_text_byte,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [31:0]                      rsp_group_first_line,
   output logic [15:0]                      rsp_group_size,
   output logic                             rsp_emit_line,
   output logic                             rsp_with_count,
   output logic                             rsp_key_overflow,
   output logic                             rsp_last,
   // configuration port
   input  logic                             csr_we,
   input  logic [adlg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [adlg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import adlg_pkg::*;

   localparam int AW = $clog2(KEY_MAX);
   localparam int QW = $bits(key_item_type) + AW;

   // configuration registers
   logic [7:0]  fields_to_skip_ff;
   logic [15:0] char_skip_ff;
   logic [15:0] char_skip_extra_ff;
   logic        show_unique_ff;
   logic        show_duplicate_ff;
   logic        prefix_count_ff;

   // front to queue
   logic          f_push, q_full;
   key_item_type  f_item;
   logic [AW-1:0] f_addr;

   // queue to back
   logic          q_valid, q_pop;
   logic [QW-1:0] q_data;
   key_item_type  q_item;
   logic [AW-1:0] q_addr;

   result_type    rsp_data;

   // Decode the register index; drop writes to unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         fields_to_skip_ff  <= '0;
         char_skip_ff       <= '0;
         char_skip_extra_ff <= '0;
         show_unique_ff     <= 1'b1;
         show_duplicate_ff  <= 1'b1;
         prefix_count_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIELDS_TO_SKIP:  fields_to_skip_ff  <= csr_wdata[7:0];
            CSR_CHAR_SKIP:       char_skip_ff       <= csr_wdata;
            CSR_CHAR_SKIP_EXTRA: char_skip_extra_ff <= csr_wdata;
            CSR_SHOW_UNIQUE:     show_unique_ff     <= csr_wdata[0];
            CSR_SHOW_DUPLICATE:  show_duplicate_ff  <= csr_wdata[0];
            CSR_PREFIX_COUNT:    prefix_count_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Front: classify each byte against the field and character skip.
   adlg_front #(.KEY_MAX(KEY_MAX)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_text_byte   (req_text_byte),
      .fields_to_skip  (fields_to_skip_ff),
      .char_skip       (char_skip_ff),
      .char_skip_extra (char_skip_extra_ff),
      .q_full          (q_full),
      .q_push          (f_push),
      .q_item          (f_item),
      .q_addr          (f_addr)
   );

   // Short queue: lets the front keep taking bytes while the back holds.
   adlg_fifo #(.WIDTH(QW), .DEPTH(MQ_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_item, f_addr}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   assign q_item = key_item_type'(q_data[QW-1:AW]);
   assign q_addr = q_data[AW-1:0];

   // Back: compare keys against the group's line, count and report groups.
   adlg_back #(.KEY_MAX(KEY_MAX)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_addr         (q_addr),
      .q_pop          (q_pop),
      .show_unique    (show_unique_ff),
      .show_duplicate (show_duplicate_ff),
      .prefix_count   (prefix_count_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

   // Unpack the result transaction onto its ports.
   assign rsp_group_first_line = rsp_data.group_first_line;
   assign rsp_group_size       = rsp_data.group_size;
   assign rsp_emit_line        = rsp_data.emit_line;
   assign rsp_with_count       = rsp_data.with_count;
   assign rsp_key_overflow     = rsp_data.key_overflow;
   assign rsp_last             = rsp_data.last;

   // A result without last is always queued together with its partner.
   a_pair_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("first result of a pair left without its partner");

   // A closed group holds at least one line.
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_group_size != 16'd0)
      else $error("result with empty group");

   // A counted line is always printed.
   a_count_prints: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_with_count |-> rsp_emit_line)
      else $error("count prefix on a line that is not printed");

endmodule

FILE: tb/tb_adjacent_duplicate_line_grouper.sv
// ----------------------------------------------------------------------------
// tb_adjacent_duplicate_line_grouper - self-checking bench for the line grouper
// Streams text bytes and end-of-input markers through the request channel
// under bursty traffic and a wandering result-side stall. A local copy of the
// grouping behaviour predicts every closed group, and each result transaction
// is checked against the oldest prediction. Skip settings change between
// phases of traffic, extremes included.
// ----------------------------------------------------------------------------
module tb_adjacent_duplicate_line_grouper;
   timeunit 1ns;
   timeprecision 1ps;

   import adlg_pkg::*;

   localparam int KEY_MAX      = 256;
   localparam int ITEM_TARGET  = 1550;
   localparam int DRAIN_CYCLES = 32;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int REPORT_MAX   = 10;

   // indexes that map to no register; writes to them must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   typedef enum logic [1:0] {
      SCAN_BLANKS,
      SCAN_FIELD,
      SCAN_CHARS,
      SCAN_KEY
   } scan_phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
   } stream_item_type;

   // -------------------------------------------------------------------------
   // block ports; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   logic                   req_type      = REQ_TEXT;
   logic [7:0]             req_text_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   logic [31:0]            rsp_group_first_line;
   logic [15:0]            rsp_group_size;
   logic                   rsp_emit_line;
   logic                   rsp_with_count;
   logic                   rsp_key_overflow;
   logic                   rsp_last;
   logic                   csr_we        = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata     = '0;

   adjacent_duplicate_line_grouper #(
      .KEY_MAX(KEY_MAX)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_text_byte        (req_text_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_group_first_line (rsp_group_first_line),
      .rsp_group_size       (rsp_group_size),
      .rsp_emit_line        (rsp_emit_line),
      .rsp_with_count       (rsp_with_count),
      .rsp_key_overflow     (rsp_key_overflow),
      .rsp_last             (rsp_last),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // grouping predictor: configuration copy, line state and the two-bank store
   // -------------------------------------------------------------------------
   logic [7:0]  cfg_fields;
   logic [15:0] cfg_chars;
   logic [15:0] cfg_extra;
   logic        cfg_unique;
   logic        cfg_duplicate;
   logic        cfg_prefix;

   logic [7:0]     line_bank [0:1][0:KEY_MAX-1];
   logic           bank_sel;
   logic [31:0]    prev_len;
   logic [31:0]    cur_len;
   logic           key_differs;
   scan_phase_type scan_phase;
   logic [7:0]     fields_seen;
   logic [16:0]    chars_seen;
   logic [15:0]    run_count;
   logic [31:0]    line_no;
   logic [31:0]    run_first_line;
   logic           have_prev;
   logic           line_open;
   logic           run_overflow;
   int             groups_this_item;

   result_type  expected_groups [$];

   function automatic void restart_stream();
      bank_sel       = 1'b0;
      prev_len       = '0;
      cur_len        = '0;
      key_differs    = 1'b0;
      scan_phase     = SCAN_BLANKS;
      fields_seen    = '0;
      chars_seen     = '0;
      run_count      = '0;
      line_no        = '0;
      run_first_line = '0;
      have_prev      = 1'b0;
      line_open      = 1'b0;
      run_overflow   = 1'b0;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_FIELDS_TO_SKIP:  cfg_fields    = value[7:0];
         CSR_CHAR_SKIP:       cfg_chars     = value[15:0];
         CSR_CHAR_SKIP_EXTRA: cfg_extra     = value[15:0];
         CSR_SHOW_UNIQUE:     cfg_unique    = value[0];
         CSR_SHOW_DUPLICATE:  cfg_duplicate = value[0];
         CSR_PREFIX_COUNT:    cfg_prefix    = value[0];
         default: ;
      endcase
   endfunction

   // describe the group that is closing
   function automatic void close_group();
      result_type r;
      logic       many;
      many               = (run_count != 16'd1);
      r.group_first_line = run_first_line;
      r.group_size       = run_count;
      r.emit_line        = cfg_prefix | (cfg_unique & ~many) | (cfg_duplicate & many);
      r.with_count       = cfg_prefix;
      r.key_overflow     = run_overflow;
      r.last             = 1'b0;
      expected_groups.push_back(r);
      groups_this_item++;
   endfunction

   // write the key byte into the free bank and compare against the group's key
   function automatic void store_key_byte(input logic [7:0] b);
      logic [31:0] pos;
      pos = cur_len;
      if (pos < KEY_MAX) begin
         line_bank[~bank_sel][pos] = b;
         if (have_prev && pos < prev_len && line_bank[bank_sel][pos] != b)
            key_differs = 1'b1;
      end
      if (pos >= prev_len)
         key_differs = 1'b1;
      if (cur_len != 32'hFFFF_FFFF)
         cur_len = cur_len + 32'd1;
   endfunction

   function automatic void scan_byte(input logic [7:0] b);
      logic        blank;
      logic [16:0] total;
      blank = (b == CH_SPACE) || (b == CH_TAB);
      total = {1'b0, cfg_chars} + {1'b0, cfg_extra};
      if (scan_phase == SCAN_BLANKS) begin
         if (!blank)
            scan_phase = SCAN_FIELD;
         return;
      end
      if (scan_phase == SCAN_FIELD) begin
         if (!blank)
            return;
         if (fields_seen < 8'd255)
            fields_seen = fields_seen + 8'd1;
         if (fields_seen < cfg_fields) begin
            scan_phase = SCAN_BLANKS;
            return;
         end
         scan_phase = SCAN_CHARS;
      end
      if (scan_phase == SCAN_CHARS) begin
         if (chars_seen < total) begin
            chars_seen = chars_seen + 17'd1;
            return;
         end
         scan_phase = SCAN_KEY;
      end
      store_key_byte(b);
   endfunction

   function automatic void close_line();
      logic overflow;
      logic same;
      overflow = (cur_len > KEY_MAX);
      same     = have_prev && !key_differs && (cur_len == prev_len);
      if (same) begin
         if (run_count != 16'hFFFF)
            run_count = run_count + 16'd1;
         run_overflow = run_overflow | overflow;
      end else begin
         if (have_prev)
            close_group();
         have_prev      = 1'b1;
         run_first_line = line_no;
         run_count      = 16'd1;
         run_overflow   = overflow;
         bank_sel       = ~bank_sel;
         prev_len       = cur_len;
      end
      line_no     = line_no + 32'd1;
      cur_len     = '0;
      key_differs = 1'b0;
      line_open   = 1'b0;
   endfunction

   function automatic void predict_request(input logic kind, input logic [7:0] b);
      result_type r;
      groups_this_item = 0;
      if (kind == REQ_TEXT) begin
         if (!line_open) begin
            line_open   = 1'b1;
            fields_seen = '0;
            chars_seen  = '0;
            scan_phase  = (cfg_fields != 8'd0) ? SCAN_BLANKS : SCAN_CHARS;
         end
         scan_byte(b);
         if (b == CH_NEWLINE)
            close_line();
      end else begin
         if (line_open)
            close_line();
         if (have_prev)
            close_group();
         restart_stream();
      end
      // flag the final result of this transaction
      if (groups_this_item != 0) begin
         r      = expected_groups.pop_back();
         r.last = 1'b1;
         expected_groups.push_back(r);
      end
   endfunction

   // -------------------------------------------------------------------------
   // failure bookkeeping
   // -------------------------------------------------------------------------
   int error_count = 0;

   function automatic void report_failure(input string msg);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display("ERROR: %s", msg);
   endfunction

   // -------------------------------------------------------------------------
   // request driver: bursts of random length separated by random gaps
   // -------------------------------------------------------------------------
   stream_item_type pending_items [$];
   stream_item_type drive_item;
   int              queued_count = 0;
   int              burst_left   = 1;
   int              gap_left     = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // the slot is free: either nothing was offered or it went this edge
         if (gap_left != 0 || pending_items.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left != 0)
               gap_left <= gap_left - 1;
         end else begin
            drive_item = pending_items.pop_front();
            req_valid     <= 1'b1;
            req_type      <= drive_item.kind;
            req_text_byte <= drive_item.data;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 60);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // result-side stall: a mode picked afresh after each run of cycles
   // -------------------------------------------------------------------------
   int stall_run  = 0;
   int stall_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(8, 150);
         end else begin
            stall_run <= stall_run - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            2: rsp_stall <= ($urandom_range(0, 7) != 0);
            default: rsp_stall <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // monitor: predict on each accepted request, then check each accepted result
   // -------------------------------------------------------------------------
   result_type seen_group;
   result_type wanted_group;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall === 1'b0)
            predict_request(req_type, req_text_byte);
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            seen_group.group_first_line = rsp_group_first_line;
            seen_group.group_size       = rsp_group_size;
            seen_group.emit_line        = rsp_emit_line;
            seen_group.with_count       = rsp_with_count;
            seen_group.key_overflow     = rsp_key_overflow;
            seen_group.last             = rsp_last;
            if (expected_groups.size() == 0) begin
               report_failure($sformatf("unexpected result: first=%0d size=%0d",
                                        rsp_group_first_line, rsp_group_size));
            end else begin
               wanted_group = expected_groups.pop_front();
               if (seen_group !== wanted_group)
                  report_failure($sformatf(
                     {"group mismatch: expected first=%0d size=%0d emit=%0b cnt=%0b ",
                      "ovf=%0b last=%0b, got first=%0d size=%0d emit=%0b cnt=%0b ",
                      "ovf=%0b last=%0b"},
                     wanted_group.group_first_line, wanted_group.group_size,
                     wanted_group.emit_line, wanted_group.with_count,
                     wanted_group.key_overflow, wanted_group.last,
                     seen_group.group_first_line, seen_group.group_size,
                     seen_group.emit_line, seen_group.with_count,
                     seen_group.key_overflow, seen_group.last));
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // watchdog
   // -------------------------------------------------------------------------
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_adjacent_duplicate_line_grouper NOT OK");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] b);
      stream_item_type it;
      it.kind = REQ_TEXT;
      it.data = b;
      pending_items.push_back(it);
      queued_count++;
   endtask

   task automatic queue_end();
      stream_item_type it;
      it.kind = REQ_END;
      it.data = 8'($urandom_range(0, 255));   // payload is don't-care here
      pending_items.push_back(it);
      queued_count++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s[i]);
   endtask

   // letters collide often so that duplicates are common; blanks form fields
   function automatic logic [7:0] pick_text_byte();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'h61;
         3, 4:    return 8'h62;
         5:       return 8'h63;
         6, 7:    return CH_SPACE;
         8:       return CH_TAB;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // hold until every request is gone and every result is in, then let the
   // pipeline run dry before touching the registers
   task automatic settle();
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_groups.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      apply_reg(idx, value);
   endtask

   // write every register; spare upper bits carry junk that must be masked
   task automatic set_regs(input logic [7:0]  skip_fields,
                           input logic [15:0] skip_chars,
                           input logic [15:0] skip_extra,
                           input logic        uniq,
                           input logic        dup,
                           input logic        with_cnt);
      logic [15:0] junk;
      junk = 16'($urandom);
      write_reg(junk[0] ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI, junk);
      write_reg(CSR_FIELDS_TO_SKIP, {junk[15:8], skip_fields});
      write_reg(CSR_CHAR_SKIP, skip_chars);
      write_reg(CSR_CHAR_SKIP_EXTRA, skip_extra);
      write_reg(CSR_SHOW_UNIQUE, {junk[15:1], uniq});
      write_reg(CSR_SHOW_DUPLICATE, {junk[14:0], dup});
      write_reg(CSR_PREFIX_COUNT, {junk[13:0], junk[15], with_cnt});
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [7:0]  body [$];
      logic [7:0]  prev_line [$];
      logic [7:0]  line [$];
      logic [7:0]  c;
      logic [7:0]  f;
      logic [15:0] chars;
      logic [15:0] extra;
      int          phase_start;
      int          budget;
      int          choice;
      int          n;
      int          k;

      // register values after reset, then a clean stream
      cfg_fields    = '0;
      cfg_chars     = '0;
      cfg_extra     = '0;
      cfg_unique    = 1'b1;
      cfg_duplicate = 1'b1;
      cfg_prefix    = 1'b0;
      restart_stream();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: empty input, a duplicate pair, byte zero and 0xFF as
      // key bytes, then an unterminated line closed by end of input
      queue_end();
      queue_text("ab\n");
      queue_text("ab\n");
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_text("\n");
      queue_text("q");
      queue_end();
      settle();

      // skip one field plus two characters; a line that ends while skipping;
      // leave the last line open across the next settings change
      set_regs(8'd1, 16'd1, 16'd1, 1'b0, 1'b1, 1'b1);
      queue_text("a\t12k\n");
      queue_text("b 34k\n");
      queue_text("zz\n");
      queue_text("c");
      settle();

      // largest skips: every key is empty, so every line matches
      set_regs(8'd255, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
      queue_text("d\n");
      queue_text("p q\n");
      queue_text("rr");
      queue_end();
      settle();

      // keys around the store size: same length and prefix with a differing
      // tail counts as equal, then a key that exactly fills the store
      set_regs(8'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0);
      for (int i = 0; i < KEY_MAX + 3; i++) begin
         c = 8'($urandom_range(0, 255));
         if (c == CH_NEWLINE)
            c = 8'h2A;
         body.push_back(c);
      end
      foreach (body[i])
         queue_byte(body[i]);
      queue_byte(CH_NEWLINE);
      foreach (body[i]) begin
         c = body[i];
         if (i >= KEY_MAX) begin
            c = c ^ 8'h01;
            if (c == CH_NEWLINE)
               c = 8'h2B;
         end
         queue_byte(c);
      end
      queue_byte(CH_NEWLINE);
      for (int i = 0; i < KEY_MAX - 1; i++)
         queue_byte(body[i]);
      queue_byte(CH_NEWLINE);
      queue_end();
      settle();

      // random phases: mostly real lines with frequent repeats, some noise
      while (queued_count < ITEM_TARGET) begin
         choice = $urandom_range(0, 9);
         f = (choice < 4) ? 8'd0 :
             (choice < 8) ? 8'($urandom_range(1, 3)) :
             (choice == 8) ? 8'd255 : 8'($urandom_range(0, 255));
         choice = $urandom_range(0, 9);
         chars = (choice < 5) ? 16'd0 :
                 (choice < 8) ? 16'($urandom_range(1, 3)) :
                 (choice == 8) ? 16'hFFFF : 16'($urandom);
         choice = $urandom_range(0, 9);
         extra = (choice < 6) ? 16'd0 :
                 (choice < 9) ? 16'($urandom_range(1, 2)) : 16'hFFFF;
         set_regs(f, chars, extra, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

         budget      = $urandom_range(40, 160);
         phase_start = queued_count;
         prev_line.delete();
         while (queued_count - phase_start < budget) begin
            choice = $urandom_range(0, 99);
            line.delete();
            if (choice < 4) begin
               // restart the stream, sometimes with a line still open
               if (choice < 2)
                  queue_byte(pick_text_byte());
               queue_end();
            end else begin
               if (choice < 12) begin
                  // garbage line of arbitrary bytes
                  n = $urandom_range(0, 6);
                  repeat (n) line.push_back(8'($urandom_range(0, 255)));
               end else if (choice < 60 && prev_line.size() > 1) begin
                  // repeat the previous line, now and then with one byte changed
                  line = prev_line;
                  void'(line.pop_back());
                  if ($urandom_range(0, 2) == 0) begin
                     k = $urandom_range(0, line.size() - 1);
                     line[k] = pick_text_byte();
                  end
               end else begin
                  n = $urandom_range(0, 8);
                  repeat (n) line.push_back(pick_text_byte());
               end
               line.push_back(CH_NEWLINE);
               foreach (line[i])
                  queue_byte(line[i]);
               prev_line = line;
            end
         end
         // usually close the stream; otherwise carry an open line over
         if ($urandom_range(0, 3) != 0)
            queue_end();
         else
            queue_byte(pick_text_byte());
         settle();
      end

      // close whatever line the last phase left open
      queue_end();
      settle();

      if (expected_groups.size() != 0)
         report_failure("results still outstanding at end of run");
      if (error_count == 0)
         $display("tb_adjacent_duplicate_line_grouper OK");
      else
         $display("tb_adjacent_duplicate_line_grouper NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/adlg_pkg.sv
rtl/adlg_ram.sv
rtl/adlg_fifo.sv
rtl/adlg_front.sv
rtl/adlg_back.sv
rtl/adjacent_duplicate_line_grouper.sv
tb/tb_adjacent_duplicate_line_grouper.sv
